FILE: sv/fir_filter_circular_unit_macros.svh
// Assertion macros for the circular-buffer FIR filter.
// Included by the modules that carry concurrent assertions; needs clk and rst_n in scope.
`ifndef FIR_FILTER_CIRCULAR_UNIT_MACROS_SVH
`define FIR_FILTER_CIRCULAR_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define FCU_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define FCU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FCU_ASSERT_IMPLY(lbl, ante, cons, msg)
`define FCU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: sv/fir_circ_pkg.sv
// Shared types and constants for the circular-buffer FIR filter.
// No dependencies.
package fir_circ_pkg;

    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 2 * SAMPLE_W;
    localparam int FRAC_W   = 15;
    localparam int ROUND_BIAS = 16384;
    localparam int SAT_MAX  = 32767;
    localparam int SAT_MIN  = -32768;

    localparam logic OP_FILTER = 1'b0;
    localparam logic OP_COEF   = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [PROD_W-1:0]   prod_t;

endpackage

FILE: sv/fir_filter_circular_unit.sv
// Circular-buffer FIR filter: delay line, coefficient table and one shared MAC.
// Depends on fir_circ_pkg and fir_filter_circular_unit_macros.svh.
//
// Usage:
//   The input channel (in_valid, in_stall) carries one word per item. With opcode
//   OP_FILTER the word holds a sample; it is written into the delay line and one
//   filtered word appears on the output channel (out_valid, out_stall). With
//   opcode OP_COEF the word loads coefficient tap_index and gives no output; an
//   index at or above TAPS is dropped.
//   A coefficient word leaves the block idle. A sample word runs the single MAC over
//   all TAPS taps, one tap per cycle, through the read, product and accumulator
//   registers; the sum is then rounded and saturated into the output register. The
//   next word is taken only once that sample is finished, so samples do not
//   overlap. in_stall is high while a sample is being filtered.
//   The output register frees the input side: a new word is accepted while a
//   result waits, but a finished sum is not loaded until the held result is taken.
//   Reset clears the delay line, the coefficient table (through per-entry valid
//   bits, so no clearing pass) and the write pointer; the block is ready at once.
`include "fir_filter_circular_unit_macros.svh"

module fir_filter_circular_unit
    import fir_circ_pkg::*;
#(
    parameter int TAPS = 32
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       opcode,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  logic [4:0]                 tap_index,
    input  logic signed [SAMPLE_W-1:0] tap_value,
    input  logic                       block_end,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [SAMPLE_W-1:0] sample_out,
    output logic                       block_end_out
);

    localparam int IW = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CW = (IW >= 5) ? IW + 1 : 5;
    localparam int AW = PROD_W + IW;
    localparam int SW = AW - FRAC_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    sample_t dl_mem [TAPS];
    sample_t cf_mem [TAPS];

    logic [1:0]        state_reg, state_next;
    logic [IW-1:0]     wp_reg, wp_next;
    logic [IW-1:0]     pos_reg, pos_next;
    logic [IW-1:0]     k_reg, k_next;
    logic              blk_reg, blk_next;
    logic [TAPS-1:0]   dl_vld_reg, cf_vld_reg;
    logic              rd_v_reg, rd_v_next, rd_last_reg, rd_last_next;
    logic              prod_v_reg, prod_last_reg;
    logic              dl_hit_reg, cf_hit_reg;
    sample_t           dl_rd_reg, cf_rd_reg;
    prod_t             prod_reg;
    logic signed [AW-1:0] acc_reg;
    logic              out_valid_reg, out_valid_next;
    sample_t           sample_out_reg, sample_out_next;
    logic              block_end_out_reg, block_end_out_next;

    logic              in_acc, fire, cwr, tap_ok, out_free, k_last;
    logic [CW-1:0]     tap_wide;
    logic [IW-1:0]     tap_addr;
    sample_t           x_op, c_op;
    logic signed [AW-1:0] acc_rnd;
    logic signed [SW-1:0] acc_shr;
    sample_t           sat_val;

    assign in_acc   = in_valid && (state_reg == ST_IDLE);
    assign fire     = in_acc && (opcode == OP_FILTER);
    assign tap_wide = CW'(tap_index);
    assign tap_ok   = tap_wide < CW'(TAPS);
    assign tap_addr = tap_wide[IW-1:0];
    assign cwr      = in_acc && (opcode == OP_COEF) && tap_ok;
    assign out_free = !out_valid_reg || !out_stall;
    assign k_last   = (k_reg == IW'(TAPS - 1));

    assign in_stall      = (state_reg != ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign sample_out    = sample_out_reg;
    assign block_end_out = block_end_out_reg;

    assign x_op = dl_hit_reg ? dl_rd_reg : '0;
    assign c_op = cf_hit_reg ? cf_rd_reg : '0;

    assign acc_rnd = acc_reg + AW'(ROUND_BIAS);
    assign acc_shr = SW'(acc_rnd >>> FRAC_W);

    always_comb
    begin
        if (acc_shr > SW'(SAT_MAX))
        begin
            sat_val = sample_t'(SAT_MAX);
        end
        else if (acc_shr < SW'(SAT_MIN))
        begin
            sat_val = sample_t'(SAT_MIN);
        end
        else
        begin
            sat_val = acc_shr[SAMPLE_W-1:0];
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        wp_next            = wp_reg;
        pos_next           = pos_reg;
        k_next             = k_reg;
        blk_next           = blk_reg;
        rd_v_next          = 1'b0;
        rd_last_next       = 1'b0;
        out_valid_next     = out_valid_reg && out_stall;
        sample_out_next    = sample_out_reg;
        block_end_out_next = block_end_out_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (fire)
                begin
                    state_next = ST_RUN;
                    k_next     = '0;
                    pos_next   = wp_reg;
                    blk_next   = block_end;
                    wp_next    = (wp_reg == IW'(TAPS - 1)) ? '0 : wp_reg + IW'(1);
                end
            end
            ST_RUN:
            begin
                rd_v_next    = 1'b1;
                rd_last_next = k_last;
                pos_next     = (pos_reg == '0) ? IW'(TAPS - 1) : pos_reg - IW'(1);
                if (k_last)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    k_next = k_reg + IW'(1);
                end
            end
            ST_DRAIN:
            begin
                if (prod_last_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next         = ST_IDLE;
                    out_valid_next     = 1'b1;
                    sample_out_next    = sat_val;
                    block_end_out_next = blk_reg;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            pos_reg       <= '0;
            k_reg         <= '0;
            dl_vld_reg    <= '0;
            cf_vld_reg    <= '0;
            dl_hit_reg    <= 1'b0;
            cf_hit_reg    <= 1'b0;
            rd_v_reg      <= 1'b0;
            rd_last_reg   <= 1'b0;
            prod_v_reg    <= 1'b0;
            prod_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            pos_reg       <= pos_next;
            k_reg         <= k_next;
            dl_hit_reg    <= dl_vld_reg[pos_reg];
            cf_hit_reg    <= cf_vld_reg[k_reg];
            rd_v_reg      <= rd_v_next;
            rd_last_reg   <= rd_last_next;
            prod_v_reg    <= rd_v_reg;
            prod_last_reg <= rd_last_reg;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                dl_vld_reg[wp_reg] <= 1'b1;
            end
            if (cwr)
            begin
                cf_vld_reg[tap_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            dl_mem[wp_reg] <= sample_in;
        end
        dl_rd_reg <= dl_mem[pos_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cwr)
        begin
            cf_mem[tap_addr] <= tap_value;
        end
        cf_rd_reg <= cf_mem[k_reg];
    end

    always_ff @(posedge clk)
    begin
        blk_reg           <= blk_next;
        sample_out_reg    <= sample_out_next;
        block_end_out_reg <= block_end_out_next;
        prod_reg          <= x_op * c_op;
        if (fire)
        begin
            acc_reg <= '0;
        end
        else if (prod_v_reg)
        begin
            acc_reg <= acc_reg + AW'(prod_reg);
        end
    end

    `FCU_ASSERT_NEXT(a_fire_runs, fire, state_reg == ST_RUN,
        "Accepted sample did not start the MAC run")
    `FCU_ASSERT_NEXT(a_coef_idle, in_acc && (opcode == OP_COEF), state_reg == ST_IDLE,
        "Coefficient word left the idle state")
    `FCU_ASSERT_IMPLY(a_idle_empty, state_reg == ST_IDLE, !rd_v_reg && !prod_v_reg,
        "MAC pipeline busy while idle")
    `FCU_ASSERT_IMPLY(a_last_tags, 1'b1,
        $onehot0({rd_last_reg, prod_last_reg, state_reg == ST_FINISH}),
        "Last-tap tags overlap")

endmodule
